@@ hw/rtl/mts_pkg.sv @@
`timescale 1ns / 1ps

package mts_pkg;

  localparam int unsigned StackDepthDef = 1024;
  localparam int unsigned DataW         = 32;
  localparam int unsigned EntriesW      = 11;
  localparam int unsigned InTdataW      = 32;
  localparam int unsigned OutTdataW     = 48;

  typedef enum logic [1:0] {
    CmdPush = 2'd0,
    CmdPop  = 2'd1,
    CmdTop  = 2'd2,
    CmdMin  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

endpackage

@@ hw/rtl/mts_ram.sv @@
`timescale 1ns / 1ps

module mts_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/min_tracking_stack.sv @@
`timescale 1ns / 1ps

// Stack of signed 32-bit values that also reports the minimum of its contents.
// Input channel s_axis: one command per beat; tuser selects push, pop, read
// top or read minimum, tdata carries the value to push.
// Output channel m_axis: one result beat per command, with read data and the
// entry count after the command in tdata and the status code in tuser.
// Each entry stores its value and the running minimum down to the bottom in
// one 64-bit single-port-write RAM with a registered read. The top
// entry is also held in registers, so push, top and minimum never wait on the
// RAM. A pop reads the entry below the top; its data is forwarded into the
// next command in the following cycle.
// Throughput: one command per cycle while the receiver keeps up. The result
// appears on m_axis in the cycle after the command beat is accepted.
// The output register is single entry: s_axis_tready is high when it is empty
// or being drained in the same cycle, so a stalled receiver holds the result
// and blocks new commands without loss.
// Reset empties the stack (count zero) and drops any pending result; RAM
// contents need no clearing since only entries below the count are read.

module min_tracking_stack #(
  parameter int unsigned STACK_DEPTH = mts_pkg::StackDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] push_value
  input  logic [mts_pkg::InTdataW-1:0]  s_axis_tdata,
  // [1:0] command
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] read_data, [42:32] entries_held, [47:43] zero
  output logic [mts_pkg::OutTdataW-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]                    m_axis_tuser
);

  import mts_pkg::*;

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned RamW  = 2 * DataW;

  logic [CntW-1:0]     fill_q, fill_d;
  logic [DataW-1:0]    top_val_q, top_val_d;
  logic [DataW-1:0]    top_min_q, top_min_d;
  logic                refill_q, refill_d;
  logic                out_valid_q, out_valid_d;
  logic [DataW-1:0]    out_data_q, out_data_d;
  status_e             out_status_q, out_status_d;
  logic [EntriesW-1:0] out_cnt_q, out_cnt_d;

  logic                accept;
  cmd_e                cmd;
  logic [DataW-1:0]    push_val;
  logic [DataW-1:0]    top_val, top_min, new_min;
  logic                is_empty, is_full;
  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [RamW-1:0]     ram_rdata;
  logic [CntW-1:0]     fill_m2;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);
  assign push_val      = s_axis_tdata[DataW-1:0];

  assign top_val  = refill_q ? ram_rdata[DataW-1:0]    : top_val_q;
  assign top_min  = refill_q ? ram_rdata[RamW-1:DataW] : top_min_q;
  assign is_empty = (fill_q == '0);
  assign is_full  = (fill_q == CntW'(STACK_DEPTH));
  assign new_min  = (!is_empty && ($signed(top_min) < $signed(push_val))) ? top_min : push_val;
  assign fill_m2  = fill_q - CntW'(2);

  assign ram_waddr = AddrW'(fill_q);
  assign ram_raddr = AddrW'(fill_m2);

  always_comb begin
    fill_d       = fill_q;
    top_val_d    = top_val;
    top_min_d    = top_min;
    refill_d     = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_cnt_d    = out_cnt_q;
    if (accept) begin
      out_valid_d  = 1'b1;
      out_data_d   = '0;
      out_status_d = StOk;
      unique case (cmd)
        CmdPush: begin
          if (is_full) begin
            out_status_d = StFull;
          end else begin
            ram_we    = 1'b1;
            top_val_d = push_val;
            top_min_d = new_min;
            fill_d    = fill_q + CntW'(1);
          end
        end
        CmdPop: begin
          if (is_empty) begin
            out_status_d = StEmpty;
          end else begin
            fill_d = fill_q - CntW'(1);
            if (fill_q > CntW'(1)) begin
              ram_re   = 1'b1;
              refill_d = 1'b1;
            end
          end
        end
        CmdTop: begin
          if (is_empty) begin
            out_status_d = StEmpty;
          end else begin
            out_data_d = top_val;
          end
        end
        CmdMin: begin
          if (is_empty) begin
            out_status_d = StEmpty;
          end else begin
            out_data_d = top_min;
          end
        end
      endcase
      out_cnt_d = EntriesW'(fill_d);
    end
  end

  mts_ram #(
    .Width(RamW),
    .Depth(STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({new_min, push_val}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      refill_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      refill_q    <= refill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_val_q    <= top_val_d;
    top_min_q    <= top_min_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutTdataW - DataW - EntriesW)'(0), out_cnt_q, out_data_q};
  assign m_axis_tuser  = out_status_q;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import mts_pkg::*;

  localparam int CycleLimit   = 400_000;
  localparam int TotalCmds    = 1800;
  localparam int HoldAtResult = 600;
  localparam int HoldCycles   = 400;

  typedef struct {
    cmd_e        cmd;
    logic [31:0] value;
    bit          wait_idle;
  } cmd_beat_t;

  typedef struct {
    logic [DataW-1:0]    read_data;
    status_e             status;
    logic [EntriesW-1:0] entries;
  } stack_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [1:0]           m_axis_tuser;

  min_tracking_stack dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // shadow stack
  logic signed [DataW-1:0] value_mem [StackDepthDef];
  logic signed [DataW-1:0] min_mem   [StackDepthDef];
  int depth_used  = 0;
  int peak_depth  = 0;
  int full_hits   = 0;
  int empty_hits  = 0;

  cmd_beat_t     cmd_q[$];
  stack_result_t result_q[$];
  int gen_fill      = 0;
  int commands_sent = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  bit offering   = 1'b0;
  bit send_quiet = 1'b0;
  int send_gap   = 0;
  bit recv_quiet = 1'b0;
  int recv_wait  = 0;
  int hold_left  = 0;
  bit hold_used  = 1'b0;
  logic long_hold;

  assign long_hold = hold_left != 0;

  function automatic stack_result_t apply_command(cmd_e cmd, logic signed [DataW-1:0] value);
    stack_result_t res;
    res.read_data = '0;
    res.status    = StOk;
    case (cmd)
      CmdPush: begin
        if (depth_used == StackDepthDef) begin
          res.status = StFull;
        end else begin
          value_mem[depth_used] = value;
          if (depth_used != 0 && min_mem[depth_used-1] < value) begin
            min_mem[depth_used] = min_mem[depth_used-1];
          end else begin
            min_mem[depth_used] = value;
          end
          depth_used++;
        end
      end
      CmdPop: begin
        if (depth_used == 0) res.status = StEmpty;
        else depth_used--;
      end
      CmdTop: begin
        if (depth_used == 0) res.status = StEmpty;
        else res.read_data = value_mem[depth_used-1];
      end
      default: begin
        if (depth_used == 0) res.status = StEmpty;
        else res.read_data = min_mem[depth_used-1];
      end
    endcase
    if (res.status == StFull) full_hits++;
    if (res.status == StEmpty) empty_hits++;
    if (depth_used > peak_depth) peak_depth = depth_used;
    res.entries = EntriesW'(depth_used);
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("ERROR result %0d %s: got 0x%0h, expected 0x%0h", results_seen, field, got,
               want);
    end
  endtask

  task automatic queue_cmd(cmd_e cmd, logic [31:0] value, bit wait_idle = 1'b0);
    cmd_beat_t beat;
    beat.cmd       = cmd;
    beat.value     = value;
    beat.wait_idle = wait_idle;
    cmd_q.insert(cmd_q.size(), beat);
    if (cmd == CmdPush && gen_fill < StackDepthDef) gen_fill++;
    if (cmd == CmdPop && gen_fill > 0) gen_fill--;
  endtask

  function automatic cmd_e pick_cmd(int push_pct, int pop_pct);
    int r = $urandom_range(0, 99);
    if (r < push_pct) return CmdPush;
    if (r < push_pct + pop_pct) return CmdPop;
    return $urandom_range(0, 1) ? CmdTop : CmdMin;
  endfunction

  // drift: values trend downward as the stack grows, so the minimum keeps moving
  function automatic logic [31:0] pick_value(bit drift);
    int unsigned r = $urandom_range(0, 15);
    if (drift) begin
      if (r != 0) return 32'(200000 - 400 * gen_fill + int'($urandom_range(0, 40000)));
      return 32'(int'($urandom_range(0, 80)) - 40);
    end
    if (r < 2) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (r < 8) return 32'(int'($urandom_range(0, 80)) - 40);
    return $urandom();
  endfunction

  // driver
  always @(posedge clk_i) begin
    cmd_beat_t beat;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      offering = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.insert(result_q.size(), apply_command(cmd_e'(s_axis_tuser), s_axis_tdata));
        commands_sent++;
        offering = 1'b0;
        if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
        send_gap = send_quiet ? 0 : $urandom_range(0, 17);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_q.size() != 0 &&
                     !(cmd_q[0].wait_idle && commands_sent != results_seen)) begin
          beat = cmd_q.pop_front();
          s_axis_tuser <= beat.cmd;
          s_axis_tdata <= beat.value;
          offering = 1'b1;
        end
      end
      s_axis_tvalid <= offering;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    stack_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata, '0);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata[DataW-1:0] !== want.read_data) begin
            report_mismatch("read_data", m_axis_tdata[DataW-1:0], want.read_data);
          end
          if (m_axis_tuser !== want.status) begin
            report_mismatch("status", m_axis_tuser, want.status);
          end
          if (m_axis_tdata[DataW+EntriesW-1:DataW] !== want.entries) begin
            report_mismatch("entries_held", m_axis_tdata[DataW+EntriesW-1:DataW],
                            want.entries);
          end
          if (m_axis_tdata[OutTdataW-1:DataW+EntriesW] !== '0) begin
            report_mismatch("tdata padding", m_axis_tdata[OutTdataW-1:DataW+EntriesW], '0);
          end
        end
        results_seen <= results_seen + 1;
        if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
        recv_wait = recv_quiet ? 0 : $urandom_range(0, 17);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      m_axis_tready <= (recv_wait == 0) && !long_hold;
    end
  end

  // one long receiver stall while the stack is filling
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && results_seen == HoldAtResult) begin
      hold_left <= HoldCycles;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d of %0d results seen", cycle_count,
               results_seen, commands_sent);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int mark;
    bit first;

    // empty stack, then extremes, ties and pops back down to empty
    queue_cmd(CmdMin, $urandom());
    queue_cmd(CmdTop, $urandom());
    queue_cmd(CmdPop, $urandom());
    queue_cmd(CmdPush, 32'h7fff_ffff);
    queue_cmd(CmdTop, $urandom());
    queue_cmd(CmdMin, $urandom());
    queue_cmd(CmdPush, 32'h8000_0000);
    queue_cmd(CmdTop, $urandom());
    queue_cmd(CmdMin, $urandom());
    queue_cmd(CmdPush, 32'h0000_0000);
    queue_cmd(CmdMin, $urandom());
    queue_cmd(CmdPush, 32'hffff_ffff);
    queue_cmd(CmdTop, $urandom());
    queue_cmd(CmdPop, $urandom());
    queue_cmd(CmdPop, $urandom());
    queue_cmd(CmdMin, $urandom());
    queue_cmd(CmdPop, $urandom());
    queue_cmd(CmdMin, $urandom());
    queue_cmd(CmdPush, 32'h7fff_ffff);
    queue_cmd(CmdMin, $urandom());
    queue_cmd(CmdPop, $urandom());
    queue_cmd(CmdPop, $urandom());
    queue_cmd(CmdPop, $urandom());
    queue_cmd(CmdTop, $urandom());

    // random walk near the bottom
    for (int i = 0; i < 350; i++) queue_cmd(pick_cmd(38, 38), pick_value(1'b0), i == 0);

    // fill to capacity
    first = 1'b1;
    while (gen_fill < StackDepthDef) begin
      queue_cmd(pick_cmd(92, 4), pick_value(1'b1), first);
      first = 1'b0;
    end

    // hover at full
    for (int i = 0; i < 80; i++) queue_cmd(pick_cmd(60, 20), pick_value(1'b0));

    // drain with mixed traffic
    mark = cmd_q.size() + (TotalCmds - cmd_q.size()) / 2;
    while (cmd_q.size() < TotalCmds || cmd_q.size() < mark + 100) begin
      queue_cmd(pick_cmd(25, 55), pick_value(1'b0), cmd_q.size() == mark);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || s_axis_tvalid || results_seen < commands_sent) begin
      @(negedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (result_q.size() != 0) report_mismatch("missing results", result_q.size(), '0);

    $display("Checked %0d stack commands, peak depth %0d of %0d", commands_sent, peak_depth,
             StackDepthDef);
    $display("Responses: %0d full-stack pushes, %0d empty-stack reads or pops", full_hits,
             empty_hits);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
